/* rtl/core/shfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shfr_pkg
// Shared types and constants of the sync header frame receiver.
// ----------------------------------------------------------------------------
package shfr_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned POS_W   = 4;

  // Payload: frame bytes three through nine
  localparam int unsigned PAYLOAD_DEPTH = 7;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_DEPTH * BYTE_W;

  // Frame layout: ten bytes, the last one carries the checksum
  localparam int unsigned FRAME_BYTES = 10;
  localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHECKSUM      = POS_W'(FRAME_BYTES - 1);

  // Register reset values
  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h5A;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = CFG_IDX_W'(1);

  // Decoded frame
  typedef struct packed {
    logic        [BYTE_W-1:0] command;
    logic signed [WORD_W-1:0] x_value;
    logic signed [WORD_W-1:0] y_value;
    logic        [WORD_W-1:0] extra_value;
  } frame_t;

endpackage
`default_nettype wire

/* rtl/core/shfr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shfr interfaces
// Valid/ready channels for received bytes, decoded frames and register writes.
// ----------------------------------------------------------------------------
interface shfr_rx_if;
  logic                        valid;
  logic                        ready;
  logic [shfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfr_frame_if;
  logic                               valid;
  logic                               ready;
  logic        [shfr_pkg::BYTE_W-1:0] command;
  logic signed [shfr_pkg::WORD_W-1:0] x_value;
  logic signed [shfr_pkg::WORD_W-1:0] y_value;
  logic        [shfr_pkg::WORD_W-1:0] extra_value;

  modport source (output valid, output command, output x_value, output y_value,
                  output extra_value, input ready);
  modport sink   (input valid, input command, input x_value, input y_value,
                  input extra_value, output ready);
endinterface

interface shfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [shfr_pkg::CFG_IDX_W-1:0] index;
  logic [shfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/shfr_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shfr_parser
// Frame state machine: header hunt, payload collection and running XOR check.
// ----------------------------------------------------------------------------
module shfr_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [shfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [shfr_pkg::BYTE_W-1:0] header_first,
  input  wire logic [shfr_pkg::BYTE_W-1:0] header_second,
  output logic                             hit,
  output shfr_pkg::frame_t                 frame
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [1:0]                       phase, phase_next;
  logic [shfr_pkg::POS_W-1:0]       pos, pos_next;
  logic [shfr_pkg::BYTE_W-1:0]      csum, csum_next;
  logic [shfr_pkg::PAYLOAD_W-1:0]   payload;
  logic                             shift_in;

  // Decide the next state for the byte at the input
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    csum_next  = csum;
    shift_in   = 1'b0;
    hit        = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (rx_byte == header_second) begin
          csum_next  = csum ^ rx_byte;
          pos_next   = shfr_pkg::POS_FIRST_PAYLOAD;
          phase_next = PH_COLLECT;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (pos < shfr_pkg::POS_CHECKSUM) begin
          shift_in  = (pos >= shfr_pkg::POS_FIRST_PAYLOAD);
          csum_next = csum ^ rx_byte;
          pos_next  = pos + shfr_pkg::POS_W'(1);
        end else begin
          phase_next = PH_HUNT;
          hit        = (rx_byte == csum);
        end
      end
      default: begin
        // Hunting, and the unused code behaves the same
        phase_next = PH_HUNT;
        if (rx_byte == header_first) begin
          csum_next  = rx_byte;
          pos_next   = shfr_pkg::POS_W'(1);
          phase_next = PH_HEADER;
        end
      end
    endcase
    hit = hit & step;
  end

  // Advance control state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= '0;
      csum  <= '0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
      csum  <= csum_next;
    end
  end

  // Shift payload bytes in from the top; the oldest ends up in the low byte
  always_ff @(posedge clk) begin
    if (step && shift_in) begin
      payload <= {rx_byte, payload[shfr_pkg::PAYLOAD_W-1:shfr_pkg::BYTE_W]};
    end
  end

  // Little-endian words fall out of the shift order directly
  assign frame.command     = payload[7:0];
  assign frame.x_value     = payload[23:8];
  assign frame.y_value     = payload[39:24];
  assign frame.extra_value = payload[55:40];

endmodule
`default_nettype wire

/* rtl/core/sync_header_frame_receiver_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_frame_receiver_top
// Two-byte sync header frame receiver with XOR checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer on rx and emits one decoded frame on
// frame for every ten-byte frame whose last byte equals the XOR of the nine
// before it; bad frames are dropped without a trace. A byte is taken every
// cycle unless a frame waits in the output register: an input register holds
// it, the state logic parses it, a good frame lands in the output register,
// so frame.valid rises once the checksum byte has passed both. A waiting frame
// holds up parsing; the input register still takes one more byte, then rx
// stalls until the frame is transferred. Header bytes are to be written
// through cfg while no frame is in progress, which the block does not enforce;
// cfg is always ready and indexes past the list are ignored.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver_top (
  input  wire logic     clk,
  input  wire logic     rst,
  shfr_rx_if.sink       rx,
  shfr_frame_if.source  frame,
  shfr_cfg_if.sink      cfg
);

  logic [shfr_pkg::BYTE_W-1:0] header_first;
  logic [shfr_pkg::BYTE_W-1:0] header_second;

  logic                        in_valid;
  logic [shfr_pkg::BYTE_W-1:0] in_byte;
  logic                        proceed;

  logic                        hit;
  shfr_pkg::frame_t            parsed;

  logic                        out_valid;
  shfr_pkg::frame_t            out_data;

  // Header registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= shfr_pkg::HEADER_FIRST_RST;
      header_second <= shfr_pkg::HEADER_SECOND_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        shfr_pkg::CFG_HEADER_FIRST:  header_first  <= cfg.data;
        shfr_pkg::CFG_HEADER_SECOND: header_second <= cfg.data;
        default: ;
      endcase
    end
  end

  // Process the held byte when the output register can take a result
  assign proceed  = in_valid && (!out_valid || frame.ready);
  assign rx.ready = !in_valid || proceed;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (proceed) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  shfr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (proceed),
    .rx_byte       (in_byte),
    .header_first  (header_first),
    .header_second (header_second),
    .hit           (hit),
    .frame         (parsed)
  );

  // Output register: load on a good frame, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= hit;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      out_data <= parsed;
    end
  end

  assign frame.valid       = out_valid;
  assign frame.command     = out_data.command;
  assign frame.x_value     = out_data.x_value;
  assign frame.y_value     = out_data.y_value;
  assign frame.extra_value = out_data.extra_value;

endmodule
`default_nettype wire
